### hdl/serial_console_command_parser_macros.svh
// Assertion macros shared by the console command parser RTL.
`ifndef SERIAL_CONSOLE_COMMAND_PARSER_MACROS_SVH
`define SERIAL_CONSOLE_COMMAND_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// Implication in the same cycle, checked on clk_i, off during reset.
`define SCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Implication into the next cycle, checked on clk_i, off during reset.
`define SCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCP_ASSERT_IMP(lbl, ante, cons, msg)
`define SCP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/scp_pkg.sv
// Shared constants, types and event codes of the console command parser.
`timescale 1ns / 1ps
`default_nettype none
package scp_pkg;

  localparam int LineCapacity = 32;
  localparam int StoreDepth   = LineCapacity - 1;
  localparam int LenW         = $clog2(LineCapacity);
  localparam int PrefixLen    = 9;
  localparam int ArgLen       = 12;
  localparam int NumFields    = 6;

  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;

  localparam logic [3:0][7:0]           KwHelp = "HELP";
  localparam logic [3:0][7:0]           KwTest = "TEST";
  localparam logic [PrefixLen-1:0][7:0] KwSet  = "SET TIME ";

  typedef enum logic [2:0] {
    EvHelp    = 3'd0,
    EvTest    = 3'd1,
    EvTime    = 3'd2,
    EvBadFmt  = 3'd3,
    EvUnknown = 3'd4,
    EvTooLong = 3'd5
  } event_e;

  typedef logic [StoreDepth-1:0][7:0] store_t;

  // Line buffer status seen by the matcher and the control
  typedef struct packed {
    logic [LenW-1:0] line_len;
    logic [LenW-1:0] text_len;
  } line_stat_t;

  // Decoded line: event plus the six time fields
  typedef struct packed {
    event_e                   ev;
    logic [NumFields-1:0][7:0] fields;
  } match_t;

endpackage
`default_nettype wire

### hdl/scp_line_buf.sv
// Line store with character count and text length up to the first zero byte.
`timescale 1ns / 1ps
`default_nettype none
`include "serial_console_command_parser_macros.svh"
module scp_line_buf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               we_i,
  input  wire logic               clr_i,
  input  wire logic [7:0]         byte_i,
  output scp_pkg::store_t         store_o,
  output scp_pkg::line_stat_t     stat_o
);

  scp_pkg::store_t               store_q;
  logic [scp_pkg::LenW-1:0]      line_len_q, line_len_d;
  logic [scp_pkg::LenW-1:0]      text_len_q, text_len_d;
  logic                          zero_seen_q, zero_seen_d;

  // Write the word at the current fill position
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < scp_pkg::StoreDepth; i++) begin
      if (we_i && line_len_q == scp_pkg::LenW'(i)) begin
        store_q[i] <= byte_i;
      end
    end
  end

  // Advance the counts, or drop the line
  always_comb begin
    line_len_d  = line_len_q;
    text_len_d  = text_len_q;
    zero_seen_d = zero_seen_q;
    if (clr_i) begin
      line_len_d  = '0;
      text_len_d  = '0;
      zero_seen_d = 1'b0;
    end else if (we_i) begin
      line_len_d = line_len_q + 1'b1;
      if (byte_i == 8'h00) begin
        zero_seen_d = 1'b1;
      end else if (!zero_seen_q) begin
        text_len_d = text_len_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q  <= '0;
      text_len_q  <= '0;
      zero_seen_q <= 1'b0;
    end else begin
      line_len_q  <= line_len_d;
      text_len_q  <= text_len_d;
      zero_seen_q <= zero_seen_d;
    end
  end

  assign store_o         = store_q;
  assign stat_o.line_len = line_len_q;
  assign stat_o.text_len = text_len_q;

  `SCP_ASSERT_IMP(a_text_within_line, 1'b1, text_len_q <= line_len_q,
                  "text length exceeds line length")
  `SCP_ASSERT_IMP(a_write_has_room, we_i,
                  line_len_q < scp_pkg::LenW'(scp_pkg::StoreDepth),
                  "write into a full line store")
  `SCP_ASSERT_NXT(a_clear_empties, clr_i, line_len_q == '0 && !zero_seen_q,
                  "line not emptied after clear")

endmodule
`default_nettype wire

### hdl/scp_field.sv
// Two-character numeric field read with blank skip, optional sign and digits.
`timescale 1ns / 1ps
`default_nettype none
module scp_field (
  input  wire logic [7:0] c0_i,
  input  wire logic [7:0] c1_i,
  output logic      [7:0] value_o
);

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  logic       neg;
  logic [7:0] mag;
  logic [7:0] tens;

  // Ten times the first digit
  assign tens = {1'b0, c0_i[3:0], 3'b000} + {3'b000, c0_i[3:0], 1'b0};

  always_comb begin
    neg = 1'b0;
    mag = '0;
    if (is_blank(c0_i)) begin
      if (is_digit(c1_i)) begin
        mag = {4'b0000, c1_i[3:0]};
      end
    end else if (c0_i == 8'h2B || c0_i == 8'h2D) begin
      neg = (c0_i == 8'h2D);
      if (is_digit(c1_i)) begin
        mag = {4'b0000, c1_i[3:0]};
      end
    end else if (is_digit(c0_i)) begin
      if (is_digit(c1_i)) begin
        mag = tens + {4'b0000, c1_i[3:0]};
      end else begin
        mag = {4'b0000, c0_i[3:0]};
      end
    end
  end

  assign value_o = neg ? (~mag + 8'd1) : mag;

endmodule
`default_nettype wire

### hdl/scp_matcher.sv
// Command decode of a finished line: keywords, time prefix and its fields.
`timescale 1ns / 1ps
`default_nettype none
module scp_matcher (
  input  wire scp_pkg::store_t     store_i,
  input  wire scp_pkg::line_stat_t stat_i,
  output scp_pkg::match_t          match_o
);

  // Fold lower case letters to upper case
  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'd32) : c;
  endfunction

  logic help_hit, test_hit, set_hit;
  logic len_kw, len_set, len_time;
  logic [scp_pkg::NumFields-1:0][7:0] fields;

  assign len_kw   = stat_i.text_len == scp_pkg::LenW'(4);
  assign len_set  = stat_i.text_len >= scp_pkg::LenW'(scp_pkg::PrefixLen);
  assign len_time = stat_i.text_len ==
                    scp_pkg::LenW'(scp_pkg::PrefixLen + scp_pkg::ArgLen);

  // Compare fixed positions against the keywords
  always_comb begin
    help_hit = 1'b1;
    test_hit = 1'b1;
    set_hit  = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (fold(store_i[i]) != scp_pkg::KwHelp[3-i]) help_hit = 1'b0;
      if (fold(store_i[i]) != scp_pkg::KwTest[3-i]) test_hit = 1'b0;
    end
    for (int i = 0; i < scp_pkg::PrefixLen; i++) begin
      if (fold(store_i[i]) != scp_pkg::KwSet[scp_pkg::PrefixLen-1-i]) set_hit = 1'b0;
    end
  end

  // Read the six two-character fields after the prefix
  for (genvar k = 0; k < scp_pkg::NumFields; k++) begin : g_field
    scp_field u_field (
      .c0_i    (store_i[scp_pkg::PrefixLen + 2*k]),
      .c1_i    (store_i[scp_pkg::PrefixLen + 2*k + 1]),
      .value_o (fields[k])
    );
  end

  always_comb begin
    match_o.fields = '0;
    if (len_kw && help_hit) begin
      match_o.ev = scp_pkg::EvHelp;
    end else if (len_kw && test_hit) begin
      match_o.ev = scp_pkg::EvTest;
    end else if (len_set && set_hit) begin
      if (len_time) begin
        match_o.ev     = scp_pkg::EvTime;
        match_o.fields = fields;
      end else begin
        match_o.ev = scp_pkg::EvBadFmt;
      end
    end else begin
      match_o.ev = scp_pkg::EvUnknown;
    end
  end

endmodule
`default_nettype wire

### hdl/serial_console_command_parser.sv
// Console command parser: input register, line buffer, decode, result register.
//
// Usage: received console bytes enter on the input channel (in_valid_i,
// in_stall_o, rx_byte_i), one word per handshake. Words other than CR and LF
// collect in a line store of up to 31 characters; CR or LF ends a nonempty
// line, which is decoded into one result word on the output channel
// (out_valid_o, out_stall_i, event_res_o and the six time fields).
// A 32nd character gives a too-long result and drops the line. Time fields
// are zero on every event but time set.
// out_valid_o rises once the ending byte, held in the input register, passes
// decode into the result register. Throughput: one byte per cycle unless a
// result waits under out_stall_i; the line store, the keyword compare and
// the field readers sit in one pass between the two registers.
// Reset empties the line and clears both valid flags; store contents are
// not reset. While a result waits under out_stall_i, bytes that only add
// to the line keep flowing; a byte that would give a second result holds
// in the input register and in_stall_o rises until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "serial_console_command_parser_macros.svh"
module serial_console_command_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        rx_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             event_res_o,
  output logic signed [7:0]      year_o,
  output logic signed [7:0]      month_o,
  output logic signed [7:0]      day_o,
  output logic signed [7:0]      hours_o,
  output logic signed [7:0]      minutes_o,
  output logic signed [7:0]      seconds_o
);

  logic                                byte_vld_q;
  logic [7:0]                          byte_q;
  logic                                res_vld_q;
  scp_pkg::event_e                     res_ev_q;
  logic [scp_pkg::NumFields-1:0][7:0]  res_fields_q;

  scp_pkg::store_t     store;
  scp_pkg::line_stat_t stat;
  scp_pkg::match_t     match;

  logic is_eol, has_line, full, produces, out_free, go;

  // Decide what the held word does
  assign is_eol   = byte_q == scp_pkg::ChCr || byte_q == scp_pkg::ChLf;
  assign has_line = stat.line_len != '0;
  assign full     = stat.line_len == scp_pkg::LenW'(scp_pkg::StoreDepth);
  assign produces = is_eol ? has_line : full;
  assign out_free = !res_vld_q || !out_stall_i;
  assign go       = byte_vld_q && (!produces || out_free);

  assign in_stall_o = byte_vld_q && !go;

  // Hold the input word until it is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      byte_vld_q <= 1'b1;
    end else if (go) begin
      byte_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

  scp_line_buf u_line_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (go && !is_eol && !full),
    .clr_i   (go && produces),
    .byte_i  (byte_q),
    .store_o (store),
    .stat_o  (stat)
  );

  scp_matcher u_matcher (
    .store_i (store),
    .stat_i  (stat),
    .match_o (match)
  );

  // Load a new result, or drop the taken one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (go && produces) begin
      res_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && produces) begin
      if (is_eol) begin
        res_ev_q     <= match.ev;
        res_fields_q <= match.fields;
      end else begin
        res_ev_q     <= scp_pkg::EvTooLong;
        res_fields_q <= '0;
      end
    end
  end

  assign out_valid_o = res_vld_q;
  assign event_res_o = res_ev_q;
  assign year_o      = $signed(res_fields_q[0]);
  assign month_o     = $signed(res_fields_q[1]);
  assign day_o       = $signed(res_fields_q[2]);
  assign hours_o     = $signed(res_fields_q[3]);
  assign minutes_o   = $signed(res_fields_q[4]);
  assign seconds_o   = $signed(res_fields_q[5]);

  `SCP_ASSERT_IMP(a_fields_zero_off_time, res_vld_q && res_ev_q != scp_pkg::EvTime,
                  res_fields_q == '0, "time fields set on a non-time event")
  `SCP_ASSERT_NXT(a_overflow_reports, go && produces && !is_eol,
                  res_vld_q && res_ev_q == scp_pkg::EvTooLong,
                  "overflow did not report too long")
  `SCP_ASSERT_IMP(a_stall_only_blocked, in_stall_o,
                  byte_vld_q && res_vld_q && out_stall_i,
                  "input stalled without a blocked result")

endmodule
`default_nettype wire

### sim/serial_console_command_parser_test.sv
// Self-checking testbench for the serial console command parser.
`timescale 1ns / 1ps
module serial_console_command_parser_test;

  localparam int LineMax     = 31;     // characters the line store holds
  localparam int TimeTextLen = 21;     // "SET TIME " plus twelve argument characters
  localparam int IdleLimit   = 2000;   // cycles without any handshake before giving up
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChVt  = 8'h0B;
  localparam logic [7:0] ChFf  = 8'h0C;
  localparam logic [7:0] ChNul = 8'h00;

  typedef struct packed {
    scp_pkg::event_e      ev;
    logic [5:0][7:0]      field;   // year, month, day, hours, minutes, seconds
  } console_result_t;

  // Line decoder and queue of pending console events
  class console_scoreboard;
    logic [7:0]      line_buf [LineMax];
    int unsigned     line_len;
    console_result_t event_q [$];
    int unsigned     failures;

    function new();
      line_len = 0;
      failures = 0;
    endfunction

    function logic [7:0] upcase(logic [7:0] c);
      if (c >= "a" && c <= "z") return c - 8'd32;
      return c;
    endfunction

    function bit has_keyword(string kw, int unsigned tlen);
      if (tlen < kw.len()) return 1'b0;
      for (int i = 0; i < kw.len(); i++)
        if (upcase(line_buf[i]) != kw[i]) return 1'b0;
      return 1'b1;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == " " || c == ChTab || c == ChVt || c == ChFf;
    endfunction

    // Read a two-character field: blanks, optional sign, digits
    function logic [7:0] read_field(logic [7:0] c0, logic [7:0] c1);
      logic [7:0] c [2];
      int         i;
      bit         neg;
      int         v;
      c[0] = c0;
      c[1] = c1;
      i = 0;
      neg = 1'b0;
      v = 0;
      while (i < 2 && is_blank(c[i])) i++;
      if (i < 2 && (c[i] == "+" || c[i] == "-")) begin
        neg = (c[i] == "-");
        i++;
      end
      while (i < 2 && c[i] >= "0" && c[i] <= "9") begin
        v = v * 10 + int'(c[i] - "0");
        i++;
      end
      if (neg) v = -v;
      return v[7:0];
    endfunction

    // Advance the line state by one accepted word; queue any event it causes
    function void note_word(logic [7:0] w);
      console_result_t r;
      int unsigned     tlen;
      r.field = '0;
      r.ev = scp_pkg::EvUnknown;
      if (w == scp_pkg::ChLf || w == scp_pkg::ChCr) begin
        if (line_len == 0) return;
        tlen = 0;
        while (tlen < line_len && line_buf[tlen] != ChNul) tlen++;
        if (tlen == 4 && has_keyword("HELP", tlen)) begin
          r.ev = scp_pkg::EvHelp;
        end else if (tlen == 4 && has_keyword("TEST", tlen)) begin
          r.ev = scp_pkg::EvTest;
        end else if (has_keyword("SET TIME ", tlen)) begin
          if (tlen == TimeTextLen) begin
            r.ev = scp_pkg::EvTime;
            for (int k = 0; k < 6; k++)
              r.field[k] = read_field(line_buf[9 + 2 * k], line_buf[10 + 2 * k]);
          end else begin
            r.ev = scp_pkg::EvBadFmt;
          end
        end else begin
          r.ev = scp_pkg::EvUnknown;
        end
        line_len = 0;
        event_q.push_back(r);
      end else if (line_len < LineMax) begin
        line_buf[line_len] = w;
        line_len++;
      end else begin
        // Drop the overflowing character along with the line
        r.ev = scp_pkg::EvTooLong;
        line_len = 0;
        event_q.push_back(r);
      end
    endfunction

    function void check_result(console_result_t got);
      console_result_t want;
      string           names [6];
      names = '{"year", "month", "day", "hours", "minutes", "seconds"};
      if (event_q.size() == 0) begin
        $display("%0t: unexpected result, event %0d", $time, got.ev);
        failures++;
        return;
      end
      want = event_q.pop_front();
      if (got.ev !== want.ev) begin
        $display("%0t: event expected %0d, got %0d", $time, want.ev, got.ev);
        failures++;
      end
      for (int k = 0; k < 6; k++)
        if (got.field[k] !== want.field[k]) begin
          $display("%0t: %s expected %0d, got %0d", $time, names[k],
                   $signed(want.field[k]), $signed(got.field[k]));
          failures++;
        end
    endfunction

    function int unsigned pending();
      return event_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [7:0]        rx_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [2:0]        event_res_o;
  logic signed [7:0] year_o, month_o, day_o, hours_o, minutes_o, seconds_o;

  console_scoreboard board;
  int unsigned       in_max;
  int unsigned       out_max;
  int unsigned       words_sent;
  int unsigned       idle_cycles;

  serial_console_command_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .event_res_o (event_res_o),
    .year_o      (year_o),
    .month_o     (month_o),
    .day_o       (day_o),
    .hours_o     (hours_o),
    .minutes_o   (minutes_o),
    .seconds_o   (seconds_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // End the run when no word moves on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o === 1'b1 && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Take result words, stalling a random number of cycles before each one
  initial begin : result_sink
    console_result_t got;
    int unsigned     n;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      n = $urandom_range(0, out_max);
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.ev = scp_pkg::event_e'(event_res_o);
      got.field = {seconds_o, minutes_o, hours_o, day_o, month_o, year_o};
      board.check_result(got);
      @(negedge clk_i);
    end
  end

  // Offer one word after a random gap; hold it until accepted
  task automatic send_word(input logic [7:0] w);
    int unsigned gap;
    gap = $urandom_range(0, in_max);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i = w;
    do @(posedge clk_i); while (in_stall_o);
    board.note_word(w);
    words_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] mixed_case(logic [7:0] c);
    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1))
      return c ^ 8'h20;
    return c;
  endfunction

  // Any byte that does not end the line
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == scp_pkg::ChLf || c == scp_pkg::ChCr);
    return c;
  endfunction

  function automatic logic [7:0] field_char();
    case ($urandom_range(0, 9))
      5:       return " ";
      6:       return ($urandom_range(0, 2) == 0) ? ChTab : ($urandom_range(0, 1) ? ChVt : ChFf);
      7:       return "+";
      8:       return "-";
      9:       return text_char();
      default: return "0" + 8'($urandom_range(0, 9));
    endcase
  endfunction

  task automatic send_text(input string s, input bit vary_case);
    for (int i = 0; i < s.len(); i++)
      send_word(vary_case ? mixed_case(s[i]) : s[i]);
  endtask

  task automatic end_line();
    send_word($urandom_range(0, 1) ? scp_pkg::ChLf : scp_pkg::ChCr);
  endtask

  // Hold the input until every pending event has come out
  task automatic drain();
    in_valid_i = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  task automatic directed_lines();
    send_text("HELP", 0);  end_line();
    send_text("help", 0);  end_line();
    send_text("hElP", 0);  end_line();
    send_text("TEST", 0);  end_line();
    send_text("tESt", 0);  end_line();
    send_text("SET TIME 240131235959", 0);  end_line();
    send_text("set time 99-9+9 1- + ", 0);  end_line();
    // Tab, vertical tab and form feed blanks ahead of the digits
    send_text("SET TIME ", 0);
    send_word(ChTab); send_word("7"); send_word(ChVt); send_word("3");
    send_word(ChFf);  send_word(ChFf);
    send_text("x1-+9a", 0);  end_line();
    send_text("SET TIME 1", 0);  end_line();
    send_text("SET TIME ", 0);  end_line();
    send_text("SET TIME 1234567890123", 0);  end_line();
    send_text("SET TIME", 0);  end_line();
    send_text("SET TIMEX123456789012", 0);  end_line();
    send_text("HELPX", 0);  end_line();
    send_text("HEL", 0);  end_line();
    // Zero byte cuts the text used for matching
    send_text("HELP", 0);  send_word(ChNul);  send_text("ZZ", 0);  end_line();
    send_word(ChNul);  send_text("ABC", 0);  end_line();
    send_text("SET TIME 1234", 0);  send_word(ChNul);  send_text("5678901", 0);  end_line();
    // Empty line, then CR followed by LF
    send_word(scp_pkg::ChLf);
    send_text("TEST", 0);  send_word(scp_pkg::ChCr);  send_word(scp_pkg::ChLf);
    // High bytes are not case folded
    send_word("H");  send_word(8'hC5);  send_word("L");  send_word("P");  end_line();
    send_word(8'hFF);  send_word(8'h80);  send_word(8'h7F);  end_line();
    // Full line, then one character too many
    for (int i = 0; i < LineMax; i++) send_word("A");
    end_line();
    for (int i = 0; i <= LineMax; i++) send_word("B");
    end_line();
    for (int i = 0; i < LineMax + 3; i++) send_word("C");
    end_line();
  endtask

  task automatic random_line();
    string       s;
    int unsigned n;
    int unsigned pos;
    case ($urandom_range(0, 9))
      0, 1: begin
        send_text($urandom_range(0, 1) ? "HELP" : "TEST", 1);
        if ($urandom_range(0, 3) == 0) begin
          send_word(ChNul);
          n = $urandom_range(0, 5);
          repeat (n) send_word(text_char());
        end
        end_line();
      end
      2, 3, 4: begin
        send_text("SET TIME ", 1);
        repeat (12) send_word(field_char());
        end_line();
      end
      5: begin
        send_text("SET TIME ", 1);
        do n = $urandom_range(0, 22); while (n == 12);
        repeat (n) send_word(field_char());
        end_line();
      end
      6: begin
        // Raw noise, line ends included
        n = $urandom_range(0, 35);
        repeat (n) send_word(8'($urandom_range(0, 255)));
        end_line();
      end
      7: begin
        n = $urandom_range(LineMax, LineMax + 9);
        repeat (n) send_word(8'($urandom_range(8'h20, 8'h7E)));
        end_line();
      end
      8: begin
        // Corrupt one character of an otherwise valid command
        case ($urandom_range(0, 2))
          0:       s = "HELP";
          1:       s = "TEST";
          default: s = "SET TIME 123456789012";
        endcase
        pos = $urandom_range(0, s.len() - 1);
        for (int i = 0; i < s.len(); i++)
          send_word(i == pos ? text_char() : mixed_case(s[i]));
        end_line();
      end
      default: begin
        n = $urandom_range(0, 3);
        repeat (n) send_word(8'($urandom_range(8'h20, 8'h7E)));
        end_line();
        if ($urandom_range(0, 1)) end_line();
      end
    endcase
  endtask

  task automatic random_lines(input int unsigned count);
    int unsigned stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      random_line();
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i = '0;
    in_max = 18;
    out_max = 18;
    words_sent = 0;
    idle_cycles = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    directed_lines();

    // Back to back on both sides
    in_max = 0;
    out_max = 0;
    random_lines(100);
    drain();

    in_max = 18;
    out_max = 18;
    random_lines(100);

    // Heavy back pressure against a fast sender
    in_max = 0;
    out_max = 18;
    random_lines(100);

    in_max = 18;
    out_max = 0;
    random_lines(100);

    in_max = 3;
    out_max = 3;
    random_lines(100);

    drain();
    repeat (8) @(negedge clk_i);
    if (board.failures == 0 && board.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
